// ===== src/smu_pkg.sv =====
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types, constants and codes of the weight update core.
// ----------------------------------------------------------------------------
`default_nettype none

package smu_pkg;

   localparam int IDX_W       = 12;
   localparam int WORD_W      = 32;
   localparam int RATE_W      = 16;
   localparam int FILL_W      = 7;
   localparam int RSUM_W      = 40;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_N_W     = 64;
   localparam int DIV_D_W     = 40;

   localparam int DEF_WEIGHT_COUNT = 4096;
   localparam int DEF_ROW_MAX      = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_UPDATE_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RATE   = 1'b1;

   localparam logic [RATE_W-1:0] RATE_RESET   = 16'd655;
   localparam logic [RATE_W-1:0] MOMENTUM_Q16 = 16'd58982;

   // ln(2) in Q56, exp input limits in Q16.16, series term limit
   localparam logic signed [63:0] LN2_Q56      = 64'sh00B17217F7D1CF7A;
   localparam logic signed [31:0] EXP_HI_LIMIT = 32'sd720896;
   localparam logic signed [31:0] EXP_LO_LIMIT = -32'sd851968;
   localparam logic [4:0]         TERM_LIMIT   = 5'd30;

   typedef enum logic [1:0] {
      MODE_SGD,
      MODE_MOMENTUM,
      MODE_SOFTMAX,
      MODE_PASS
   } mode_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_CLEAR,
      OP_STEP,
      OP_MOD_HI,
      OP_MOD_LO,
      OP_VREAD,
      OP_VMUL,
      OP_VADD,
      OP_VWRITE,
      OP_RESULT,
      OP_EXP_INIT,
      OP_RED,
      OP_SER_INIT,
      OP_PP_CLR,
      OP_PP,
      OP_DIV_TERM,
      OP_TERM_UPD,
      OP_EXP_FIN,
      OP_PUSH,
      OP_FL_READ,
      OP_DIV_ROW,
      OP_FL_OUT
   } dp_op_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_STEP,
      S_MOD_HI,
      S_MOD_LO,
      S_VREAD,
      S_VMUL,
      S_VADD,
      S_VWRITE,
      S_RESULT,
      S_E_INIT,
      S_E_RED,
      S_E_LOOP,
      S_E_PP,
      S_E_DIV,
      S_E_DWAIT,
      S_PUSH,
      S_FL_READ,
      S_FL_DIV,
      S_FL_WAIT,
      S_FL_OUT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     clr_last;
      logic     exp_early;
      logic     red_ok;
      logic     ser_done;
      logic     pp_last;
      logic     div_busy;
      logic     flush_now;
      logic     fl_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/smu_div.sv =====
// ----------------------------------------------------------------------------
// smu_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smu_div
   import smu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    busy,
   output logic [DIV_N_W-1:0]      quotient
);

   logic                             busy_ff;
   logic [$clog2(DIV_N_W)-1:0]       cnt_ff;
   logic [DIV_N_W-1:0]               quo_ff;
   logic [DIV_D_W-1:0]               rem_ff;
   logic [DIV_D_W-1:0]               dvs_ff;
   logic [DIV_D_W:0]                 shift_in;
   logic                             fits_in;

   assign shift_in = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits_in  = (shift_in >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
         cnt_ff <= ($clog2(DIV_N_W))'(DIV_N_W - 1);
      end else if (busy_ff) begin
         rem_ff <= fits_in ? DIV_D_W'(shift_in - {1'b0, dvs_ff}) : shift_in[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits_in};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/smu_datapath.sv =====
// ----------------------------------------------------------------------------
// smu_datapath
// Registers, velocity store, row buffers, multiplier and exp series datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module smu_datapath
   import smu_pkg::*;
#(
   parameter int WEIGHT_COUNT = DEF_WEIGHT_COUNT,
   parameter int ROW_MAX      = DEF_ROW_MAX
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic [IDX_W-1:0]         req_element_index,
   input  wire logic signed [WORD_W-1:0] req_weight_in,
   input  wire logic signed [WORD_W-1:0] req_gradient_in,
   input  wire logic                     req_row_end,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 status,
   output logic [IDX_W-1:0]              rsp_result_index,
   output logic signed [WORD_W-1:0]      rsp_weight_out,
   output logic                          rsp_last_of_run
);

   localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
   localparam int RW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
   localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [35:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         return 32'sh80000000;
      end
      return v[WORD_W-1:0];
   endfunction

   // six steps of the binary reduction modulo WEIGHT_COUNT
   function automatic logic [IDX_W-1:0] mod_half(input logic [IDX_W-1:0] v, input int top);
      logic [27:0] r;
      logic [27:0] cand;
      int          i;
      r = 28'(v);
      for (i = 0; i < 6; i++) begin
         cand = 28'(WEIGHT_COUNT) << (top - i);
         if (r >= cand) begin
            r = r - cand;
         end
      end
      return r[IDX_W-1:0];
   endfunction

   // configuration and control state
   mode_type              mode_ff;
   logic [RATE_W-1:0]     rate_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic [RSUM_W-1:0]     rsum_ff;
   logic [FILL_W-1:0]     rd_ptr_ff;
   logic [AW-1:0]         clr_ff;

   // item registers
   logic [IDX_W-1:0]           idx_ff;
   logic signed [WORD_W-1:0]   w_ff;
   logic signed [WORD_W-1:0]   g_ff;
   logic                       end_ff;
   logic [IDX_W-1:0]           slot_ff;
   logic signed [33:0]         step_ff;
   logic signed [WORD_W-1:0]   vrd_ff;
   logic signed [32:0]         vm_ff;
   logic signed [WORD_W-1:0]   vnew_ff;

   // exp series
   logic signed [63:0]    x_ff;
   logic signed [5:0]     k_ff;
   logic [59:0]           t_ff;
   logic [60:0]           term_ff;
   logic [63:0]           esum_ff;
   logic [4:0]            j_ff;
   logic [127:0]          acc_ff;
   logic [1:0]            pp_ff;
   logic [WORD_W-1:0]     e_ff;

   // row flush
   logic [WORD_W-1:0]     rexp_ff;
   logic [IDX_W-1:0]      ridx_ff;

   // output register
   logic [IDX_W-1:0]           out_idx_ff;
   logic signed [WORD_W-1:0]   out_w_ff;
   logic                       out_last_ff;

   logic signed [WORD_W-1:0] vel_mem [WEIGHT_COUNT];
   logic [WORD_W-1:0]        exp_mem [ROW_MAX];
   logic [IDX_W-1:0]         idx_mem [ROW_MAX];

   logic [AW-1:0]              vslot;
   logic signed [48:0]         step_prod;
   logic signed [48:0]         vm_prod;
   logic signed [33:0]         step_in;
   logic signed [32:0]         vm_in;
   logic signed [WORD_W-1:0]   vnew_in;
   logic signed [WORD_W-1:0]   result_in;
   logic                       exp_hi;
   logic                       exp_lo;
   logic [31:0]                mul_a;
   logic [31:0]                mul_b;
   logic [63:0]                mul_p;
   logic [127:0]               pp_shift;
   logic signed [7:0]          s_wide;
   logic [5:0]                 s_amt;
   logic [64:0]                half;
   logic [64:0]                rnd;
   logic [WORD_W-1:0]          exp_fin_in;
   logic [48:0]                row_num;
   logic                       div_start;
   logic [DIV_N_W-1:0]         div_dividend;
   logic [DIV_D_W-1:0]         div_divisor;
   logic                       div_busy;
   logic [DIV_N_W-1:0]         div_q;
   logic [WORD_W-1:0]          row_q_in;
   logic                       fl_last;

   assign vslot = AW'(slot_ff);

   // SGD step and momentum products
   assign step_prod = g_ff * $signed({1'b0, rate_ff});
   assign vm_prod   = vrd_ff * $signed({1'b0, MOMENTUM_Q16});
   assign step_in   = 34'((step_prod + 49'sd32768) >>> 16);
   assign vm_in     = 33'((vm_prod + 49'sd32768) >>> 16);
   assign vnew_in   = sat32(36'(vm_ff) + 36'(step_ff));

   always_comb begin
      case (mode_ff)
         MODE_SGD:      result_in = sat32(36'(w_ff) - 36'(step_ff));
         MODE_MOMENTUM: result_in = sat32(36'(w_ff) - 36'(vnew_ff));
         default:       result_in = w_ff;
      endcase
   end

   assign exp_hi = (w_ff > EXP_HI_LIMIT);
   assign exp_lo = (w_ff < EXP_LO_LIMIT);

   // one 32x32 partial product of term * t per cycle
   always_comb begin
      case (pp_ff)
         2'd0: begin
            mul_a = term_ff[31:0];
            mul_b = t_ff[31:0];
         end
         2'd1: begin
            mul_a = term_ff[31:0];
            mul_b = 32'(t_ff[59:32]);
         end
         2'd2: begin
            mul_a = 32'(term_ff[60:32]);
            mul_b = t_ff[31:0];
         end
         default: begin
            mul_a = 32'(term_ff[60:32]);
            mul_b = 32'(t_ff[59:32]);
         end
      endcase
      mul_p = mul_a * mul_b;
      case (pp_ff)
         2'd0:    pp_shift = 128'(mul_p);
         2'd1:    pp_shift = 128'(mul_p) << 32;
         2'd2:    pp_shift = 128'(mul_p) << 32;
         default: pp_shift = 128'(mul_p) << 64;
      endcase
   end

   // scale the series sum by 2^k and round to Q16.16
   always_comb begin
      s_wide = 8'sd44 - 8'(k_ff);
      s_amt  = s_wide[5:0];
      half   = 65'(1) << (s_amt - 6'd1);
      rnd    = (65'(esum_ff) + half) >> s_amt;
      if (k_ff >= 6'sd15) begin
         exp_fin_in = 32'h7FFFFFFF;
      end else if (k_ff <= -6'sd18) begin
         exp_fin_in = '0;
      end else if (rnd > 65'h07FFFFFFF) begin
         exp_fin_in = 32'h7FFFFFFF;
      end else begin
         exp_fin_in = rnd[WORD_W-1:0];
      end
   end

   assign row_num      = 49'({rexp_ff, 16'b0}) + 49'(rsum_ff[RSUM_W-1:1]);
   assign div_start    = (cmd.op == OP_DIV_TERM) || (cmd.op == OP_DIV_ROW);
   assign div_dividend = (cmd.op == OP_DIV_TERM) ? acc_ff[123:60] : DIV_N_W'(row_num);
   assign div_divisor  = (cmd.op == OP_DIV_TERM) ? DIV_D_W'(j_ff) : rsum_ff;

   smu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      if (rsum_ff == '0) begin
         row_q_in = '0;
      end else if (div_q > 64'h7FFFFFFF) begin
         row_q_in = 32'h7FFFFFFF;
      end else begin
         row_q_in = div_q[WORD_W-1:0];
      end
   end

   assign fl_last = (rd_ptr_ff == fill_ff - 7'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SGD;
         rate_ff   <= RATE_RESET;
         fill_ff   <= '0;
         rsum_ff   <= '0;
         rd_ptr_ff <= '0;
         clr_ff    <= '0;
      end else begin
         if (csr_write_enable && csr_index == REG_UPDATE_MODE) begin
            mode_ff <= mode_type'(csr_write_data[1:0]);
         end
         if (csr_write_enable && csr_index == REG_STEP_RATE) begin
            rate_ff <= csr_write_data[RATE_W-1:0];
         end
         case (cmd.op)
            OP_CLEAR: clr_ff <= clr_ff + 1'b1;
            OP_PUSH: begin
               fill_ff <= fill_ff + 7'd1;
               rsum_ff <= rsum_ff + RSUM_W'(e_ff);
            end
            OP_FL_OUT: begin
               if (fl_last) begin
                  fill_ff   <= '0;
                  rsum_ff   <= '0;
                  rd_ptr_ff <= '0;
               end else begin
                  rd_ptr_ff <= rd_ptr_ff + 7'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            idx_ff <= req_element_index;
            w_ff   <= req_weight_in;
            g_ff   <= req_gradient_in;
            end_ff <= req_row_end;
         end
         OP_MOD_HI: slot_ff <= mod_half(idx_ff, 11);
         OP_MOD_LO: slot_ff <= mod_half(slot_ff, 5);
         OP_STEP:   step_ff <= step_in;
         OP_VREAD:  step_ff <= step_in;
         OP_VMUL:   vm_ff   <= vm_in;
         OP_VADD:   vnew_ff <= vnew_in;
         OP_EXP_INIT: begin
            x_ff <= 64'(w_ff) <<< 40;
            k_ff <= '0;
            e_ff <= exp_hi ? 32'h7FFFFFFF : 32'h0;
         end
         OP_RED: begin
            if (x_ff[63]) begin
               x_ff <= x_ff + LN2_Q56;
               k_ff <= k_ff - 6'sd1;
            end else begin
               x_ff <= x_ff - LN2_Q56;
               k_ff <= k_ff + 6'sd1;
            end
         end
         OP_SER_INIT: begin
            t_ff    <= {x_ff[55:0], 4'b0};
            term_ff <= 61'(1) << 60;
            esum_ff <= 64'(1) << 60;
            j_ff    <= 5'd1;
         end
         OP_PP_CLR: begin
            acc_ff <= '0;
            pp_ff  <= '0;
         end
         OP_PP: begin
            acc_ff <= acc_ff + pp_shift;
            pp_ff  <= pp_ff + 2'd1;
         end
         OP_TERM_UPD: begin
            term_ff <= div_q[60:0];
            esum_ff <= esum_ff + div_q;
            j_ff    <= j_ff + 5'd1;
         end
         OP_EXP_FIN: e_ff <= exp_fin_in;
         OP_RESULT: begin
            out_idx_ff  <= idx_ff;
            out_w_ff    <= result_in;
            out_last_ff <= 1'b1;
         end
         OP_FL_OUT: begin
            out_idx_ff  <= ridx_ff;
            out_w_ff    <= row_q_in;
            out_last_ff <= fl_last;
         end
         default: ;
      endcase
   end

   // velocity store: clearing pass after reset, then one read or write a cycle
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR) begin
         vel_mem[clr_ff] <= '0;
      end else if (cmd.op == OP_VWRITE) begin
         vel_mem[vslot] <= vnew_ff;
      end
      if (cmd.op == OP_VREAD) begin
         vrd_ff <= vel_mem[vslot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUSH) begin
         exp_mem[fill_ff[RW-1:0]] <= e_ff;
         idx_mem[fill_ff[RW-1:0]] <= idx_ff;
      end
      if (cmd.op == OP_FL_READ) begin
         rexp_ff <= exp_mem[rd_ptr_ff[RW-1:0]];
         ridx_ff <= idx_mem[rd_ptr_ff[RW-1:0]];
      end
   end

   always_comb begin
      status.mode      = mode_ff;
      status.clr_last  = (clr_ff == AW'(WEIGHT_COUNT - 1));
      status.exp_early = exp_hi || exp_lo;
      status.red_ok    = !x_ff[63] && (x_ff < LN2_Q56);
      status.ser_done  = (j_ff == TERM_LIMIT) || (term_ff == '0);
      status.pp_last   = (pp_ff == 2'd3);
      status.div_busy  = div_busy;
      status.flush_now = end_ff || (fill_ff == 7'(ROW_MAX - 1));
      status.fl_last   = fl_last;
   end

   assign rsp_result_index = out_idx_ff;
   assign rsp_weight_out   = out_w_ff;
   assign rsp_last_of_run  = out_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'(ROW_MAX))
      else $error("row fill beyond buffer depth");

   a_flush_in_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FL_READ) |-> (rd_ptr_ff < fill_ff))
      else $error("flush read past row fill");

   a_empty_row_sum: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (rsum_ff == '0))
      else $error("row sum left over with an empty row");

endmodule

`default_nettype wire

// ===== src/smu_ctrl.sv =====
// ----------------------------------------------------------------------------
// smu_ctrl
// Sequencer: walks each item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module smu_ctrl
   import smu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      load_out;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (status.clr_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               case (status.mode)
                  MODE_SGD:      state_in = S_STEP;
                  MODE_MOMENTUM: state_in = S_MOD_HI;
                  MODE_SOFTMAX:  state_in = S_E_INIT;
                  default:       state_in = S_RESULT;
               endcase
            end
         end
         S_STEP:    state_in = S_RESULT;
         S_MOD_HI:  state_in = S_MOD_LO;
         S_MOD_LO:  state_in = S_VREAD;
         S_VREAD:   state_in = S_VMUL;
         S_VMUL:    state_in = S_VADD;
         S_VADD:    state_in = S_VWRITE;
         S_VWRITE:  state_in = S_RESULT;
         S_RESULT:  if (out_free) state_in = S_IDLE;
         S_E_INIT:  state_in = status.exp_early ? S_PUSH : S_E_RED;
         S_E_RED:   if (status.red_ok) state_in = S_E_LOOP;
         S_E_LOOP:  state_in = status.ser_done ? S_PUSH : S_E_PP;
         S_E_PP:    if (status.pp_last) state_in = S_E_DIV;
         S_E_DIV:   state_in = S_E_DWAIT;
         S_E_DWAIT: if (!status.div_busy) state_in = S_E_LOOP;
         S_PUSH:    state_in = status.flush_now ? S_FL_READ : S_IDLE;
         S_FL_READ: state_in = S_FL_DIV;
         S_FL_DIV:  state_in = S_FL_WAIT;
         S_FL_WAIT: if (!status.div_busy) state_in = S_FL_OUT;
         S_FL_OUT: begin
            if (out_free) begin
               state_in = status.fl_last ? S_IDLE : S_FL_READ;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_IDLE;
      case (state_ff)
         S_CLEAR:   cmd.op = OP_CLEAR;
         S_IDLE:    if (req_valid) cmd.op = OP_LOAD;
         S_STEP:    cmd.op = OP_STEP;
         S_MOD_HI:  cmd.op = OP_MOD_HI;
         S_MOD_LO:  cmd.op = OP_MOD_LO;
         S_VREAD:   cmd.op = OP_VREAD;
         S_VMUL:    cmd.op = OP_VMUL;
         S_VADD:    cmd.op = OP_VADD;
         S_VWRITE:  cmd.op = OP_VWRITE;
         S_RESULT:  if (out_free) cmd.op = OP_RESULT;
         S_E_INIT:  cmd.op = OP_EXP_INIT;
         S_E_RED:   cmd.op = status.red_ok ? OP_SER_INIT : OP_RED;
         S_E_LOOP:  cmd.op = status.ser_done ? OP_EXP_FIN : OP_PP_CLR;
         S_E_PP:    cmd.op = OP_PP;
         S_E_DIV:   cmd.op = OP_DIV_TERM;
         S_E_DWAIT: if (!status.div_busy) cmd.op = OP_TERM_UPD;
         S_PUSH:    cmd.op = OP_PUSH;
         S_FL_READ: cmd.op = OP_FL_READ;
         S_FL_DIV:  cmd.op = OP_DIV_ROW;
         S_FL_OUT:  if (out_free) cmd.op = OP_FL_OUT;
         default:   cmd.op = OP_IDLE;
      endcase
   end

   assign load_out     = (cmd.op == OP_RESULT) || (cmd.op == OP_FL_OUT);
   // hold the beat while stalled, drop it once taken
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while holding a beat");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLEAR) && !rsp_valid_ff)
      else $error("reset did not start the clearing pass");

   a_pp_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_E_PP) && status.pp_last |=> (state_ff == S_E_DIV))
      else $error("partial products did not hand over to the divider");

endmodule

`default_nettype wire

// ===== src/sgd_momentum_softmax_update_core.sv =====
// ----------------------------------------------------------------------------
// sgd_momentum_softmax_update_core
// Weight update core: plain SGD, momentum SGD and row softmax, Q16.16.
// ----------------------------------------------------------------------------
// After reset the core clears the velocity store, one entry a cycle, and
// takes no item meanwhile (configuration writes are taken). One item at a
// time: plain SGD computes its step, pass-through mode goes straight to the
// result, and momentum runs index reduction, store read, 0.9 multiply, add
// and write-back. A softmax element runs a Taylor series for exp on a shared
// 32x32 multiplier and a radix-2 divider: range reduction, then at most 29
// series terms. The element that ends a row, or fills the row buffer, then
// flushes it, dividing each buffered exp by the row sum. A finished result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_momentum_softmax_update_core
   import smu_pkg::*;
#(
   parameter int WEIGHT_COUNT = DEF_WEIGHT_COUNT,
   parameter int ROW_MAX      = DEF_ROW_MAX
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [IDX_W-1:0]         req_element_index,
   input  wire logic signed [WORD_W-1:0] req_weight_in,
   input  wire logic signed [WORD_W-1:0] req_gradient_in,
   input  wire logic                     req_row_end,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [IDX_W-1:0]              rsp_result_index,
   output logic signed [WORD_W-1:0]      rsp_weight_out,
   output logic                          rsp_last_of_run
);

   dp_cmd_type    cmd;
   dp_status_type status;

   smu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   smu_datapath #(
      .WEIGHT_COUNT (WEIGHT_COUNT),
      .ROW_MAX      (ROW_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_element_index (req_element_index),
      .req_weight_in     (req_weight_in),
      .req_gradient_in   (req_gradient_in),
      .req_row_end       (req_row_end),
      .cmd               (cmd),
      .status            (status),
      .rsp_result_index  (rsp_result_index),
      .rsp_weight_out    (rsp_weight_out),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire
